[src/ecpm_pkg.sv]
// Shared types and constants for the prime-field point multiply block.
package ecpm_pkg;

  localparam int unsigned FLD_W = 32;
  localparam int unsigned SCL_W = 64;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_MUL = 1'b1;

  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_COEFF_A = 2'd1;
  localparam logic [1:0] REG_COEFF_B = 2'd2;

  typedef struct packed {
    logic             command;
    logic [FLD_W-1:0] first_x;
    logic [FLD_W-1:0] first_y;
    logic             first_at_infinity;
    logic [FLD_W-1:0] second_x;
    logic [FLD_W-1:0] second_y;
    logic             second_at_infinity;
    logic [SCL_W-1:0] scalar;
  } ecpm_in_t;

  typedef struct packed {
    logic [FLD_W-1:0] result_x;
    logic [FLD_W-1:0] result_y;
    logic             result_at_infinity;
    logic             curve_singular;
  } ecpm_out_t;

endpackage

[src/ec_prime_point_multiply.sv]
// Prime-field elliptic-curve point add and Montgomery-ladder scalar multiply.
//
// Usage: configure modulus, coeff_a and coeff_b through the cfg_ APB port
// (byte addresses 0, 4, 8) while the block is idle. Present an item on in_data
// with in_start high while in_busy is low; the item is taken at that edge and
// in_busy rises. When the result is ready, out_valid pulses for one cycle with
// the result on out_data; the receiver cannot stall, so the result is dropped
// onto the port exactly once and in_busy falls in the same cycle.
// Cost: field multiplies and reductions run through one bit-serial modular
// multiplier; field adds and subtracts are combinational. Every item first
// reduces six operands and computes the discriminant (five products).
// A point add costs one Fermat inversion (about 2*FLD_W products) plus a
// handful of products. A multiply runs two point operations per scalar bit.
// One item is in flight at a time.
// Reset (synchronous, rst_n low) returns the registers to p=2^32-5, a=0,
// b=7 and the sequencer to idle.
module ec_prime_point_multiply
  import ecpm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_start,
  output logic            in_busy,
  input  ecpm_in_t        in_data,
  output logic            out_valid,
  output ecpm_out_t       out_data,
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [3:0]      cfg_paddr,
  input  logic [31:0]     cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);

  localparam int unsigned FW  = FLD_W;
  localparam int unsigned SW  = SCL_W;
  localparam int unsigned CW  = $clog2(FW + 2) + 1;
  localparam int unsigned KW  = $clog2(SW + 1);
  localparam int unsigned EW  = $clog2(FW + 1);

  // sequencer states
  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_RED    = 6'd1;   // reduce operands by p (serial)
  localparam logic [5:0] S_DISC0  = 6'd2;
  localparam logic [5:0] S_DISC1  = 6'd3;
  localparam logic [5:0] S_DISC2  = 6'd4;
  localparam logic [5:0] S_DISC3  = 6'd5;
  localparam logic [5:0] S_DISC4  = 6'd6;
  localparam logic [5:0] S_DISC5  = 6'd7;
  localparam logic [5:0] S_DISPATCH = 6'd8;
  localparam logic [5:0] S_LADDER = 6'd9;
  localparam logic [5:0] S_PA_CHK = 6'd10;
  localparam logic [5:0] S_PA_D0  = 6'd11;  // 3x
  localparam logic [5:0] S_PA_D1  = 6'd12;  // 3x*x
  localparam logic [5:0] S_PA_S0  = 6'd13;
  localparam logic [5:0] S_INV    = 6'd14;
  localparam logic [5:0] S_INV_M  = 6'd15;
  localparam logic [5:0] S_LAM    = 6'd16;
  localparam logic [5:0] S_X3     = 6'd17;
  localparam logic [5:0] S_Y3     = 6'd18;
  localparam logic [5:0] S_PA_DONE = 6'd19;
  localparam logic [5:0] S_OUT    = 6'd20;
  localparam logic [5:0] S_WAITM  = 6'd21;

  // configuration registers
  logic [FW-1:0] modulus_r, coeff_a_r, coeff_b_r;
  logic          cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= FW'(64'd4294967291);
      coeff_a_r <= '0;
      coeff_b_r <= FW'(7);
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_MODULUS: modulus_r <= cfg_pwdata[FW-1:0];
        REG_COEFF_A: coeff_a_r <= cfg_pwdata[FW-1:0];
        REG_COEFF_B: coeff_b_r <= cfg_pwdata[FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_MODULUS: cfg_prdata = 32'(modulus_r);
      REG_COEFF_A: cfg_prdata = 32'(coeff_a_r);
      REG_COEFF_B: cfg_prdata = 32'(coeff_b_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Field helpers (one add/compare wide)
  // ---------------------------------------------------------------
  logic [FW-1:0] p_r;

  function automatic logic [FW-1:0] f_add(input logic [FW-1:0] u, input logic [FW-1:0] v,
                                          input logic [FW-1:0] p);
    logic [FW:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[FW-1:0];
  endfunction

  function automatic logic [FW-1:0] f_sub(input logic [FW-1:0] u, input logic [FW-1:0] v,
                                          input logic [FW-1:0] p);
    return (u >= v) ? (u - v) : (u + (p - v));
  endfunction

  // ---------------------------------------------------------------
  // Bit-serial modular multiplier: r = 2r (+u), one scalar bit a cycle.
  // Also serves serial reduction: mode red shifts in value bits.
  // The u operand must be below p; v may be any bit pattern.
  // ---------------------------------------------------------------
  logic          mul_go, mul_red, mul_busy_r, mul_done;
  logic [FW-1:0] mul_u, mul_v;
  logic [FW-1:0] mu_u_r, mu_v_r, mu_acc_r;
  logic          mu_red_r;
  logic [CW-1:0] mu_cnt_r;
  logic [FW-1:0] mu_dbl;

  always_comb begin
    mu_dbl = f_add(mu_acc_r, mu_acc_r, p_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done   <= 1'b0;
    end else begin
      mul_done <= 1'b0;
      if (mul_go) begin
        mul_busy_r <= 1'b1;
        mu_cnt_r   <= CW'(FW);
      end else if (mul_busy_r) begin
        mu_cnt_r <= mu_cnt_r - 1'b1;
        if (mu_cnt_r == CW'(1)) begin
          mul_busy_r <= 1'b0;
          mul_done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_go) begin
      mu_u_r   <= mul_u;
      mu_v_r   <= mul_v;
      mu_red_r <= mul_red;
      mu_acc_r <= '0;
    end else if (mul_busy_r) begin
      mu_v_r <= {mu_v_r[FW-2:0], 1'b0};
      if (mu_red_r)
        mu_acc_r <= mu_v_r[FW-1] ? f_add(mu_dbl, FW'(1), p_r) : mu_dbl;
      else
        mu_acc_r <= mu_v_r[FW-1] ? f_add(mu_dbl, mu_u_r, p_r) : mu_dbl;
    end
  end

  // ---------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------
  logic [5:0]    st_r, ret_r;
  ecpm_in_t      item_r;
  logic [FW-1:0] a_r, b_r;
  logic [2:0]    red_idx_r;
  logic [FW-1:0] t1_r;
  logic          sing_r;
  // ladder registers
  logic [FW-1:0] r0x_r, r0y_r, r1x_r, r1y_r;
  logic          r0i_r, r1i_r;
  logic [SW-1:0] k_r;
  logic [KW-1:0] kcnt_r;
  logic          lstep_r;           // 0: first op of ladder step, 1: second
  // point-add operands/result
  logic [FW-1:0] px_r, py_r, qx_r, qy_r, rx_r, ry_r;
  logic          pi_r, qi_r, ri_r;
  logic [FW-1:0] num_r, den_r, lam_r;
  // inversion
  logic [FW-1:0] inv_b_r, inv_e_r, inv_r_r;
  logic [EW-1:0] inv_cnt_r;
  logic          inv_ph_r;          // 0: result multiply, 1: squaring
  logic          out_v_r;
  ecpm_out_t     out_r;

  logic [FW-1:0] p_eff;
  assign p_eff = (modulus_r == '0) ? FW'(1) : modulus_r;

  assign in_busy   = (st_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  function automatic logic [FW-1:0] red_src_next(input logic [2:0] i);
    case (i)
      3'd1:    return coeff_b_r;
      3'd2:    return item_r.first_x[FW-1:0];
      3'd3:    return item_r.first_y[FW-1:0];
      3'd4:    return item_r.second_x[FW-1:0];
      default: return item_r.second_y[FW-1:0];
    endcase
  endfunction

  // ladder step operand select
  logic kbit;
  assign kbit = k_r[SW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      out_v_r <= 1'b0;
      mul_go  <= 1'b0;
    end else begin
      out_v_r <= 1'b0;
      mul_go  <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_start) begin
            item_r    <= in_data;
            p_r       <= p_eff;
            red_idx_r <= 3'd0;
            st_r      <= S_RED;
            mul_go    <= 1'b1;
            mul_red   <= 1'b1;
            mul_v     <= coeff_a_r;
            mul_u     <= '0;
          end
        end
        S_RED: begin
          if (mul_done) begin
            case (red_idx_r)
              3'd0: a_r <= mu_acc_r;
              3'd1: b_r <= mu_acc_r;
              3'd2: px_r <= mu_acc_r;
              3'd3: py_r <= mu_acc_r;
              3'd4: qx_r <= mu_acc_r;
              default: qy_r <= mu_acc_r;
            endcase
            if (red_idx_r == 3'd5) begin
              st_r    <= S_DISC0;
              mul_go  <= 1'b1;
              mul_red <= 1'b0;
              mul_u   <= a_r;
              mul_v   <= a_r;
            end else begin
              red_idx_r <= red_idx_r + 1'b1;
              mul_go    <= 1'b1;
              mul_v     <= red_src_next(red_idx_r + 1'b1);
            end
          end
        end
        S_DISC0: if (mul_done) begin      // a*a
          mul_go <= 1'b1; mul_u <= mu_acc_r; mul_v <= a_r;
          st_r <= S_DISC1;
        end
        S_DISC1: if (mul_done) begin      // a^3, then 4*a^3
          mul_go <= 1'b1; mul_u <= mu_acc_r; mul_v <= FW'(4);
          st_r <= S_DISC2;
        end
        S_DISC2: if (mul_done) begin
          t1_r <= mu_acc_r; mul_go <= 1'b1; mul_u <= b_r; mul_v <= b_r;
          st_r <= S_DISC3;
        end
        S_DISC3: if (mul_done) begin
          mul_go <= 1'b1; mul_u <= mu_acc_r; mul_v <= FW'(27);
          st_r <= S_DISC4;
        end
        S_DISC4: if (mul_done) begin
          sing_r <= (f_add(t1_r, mu_acc_r, p_r) == '0);
          st_r   <= S_DISC5;
        end
        S_DISC5: begin
          // spare state before dispatch
          st_r <= S_DISPATCH;
        end
        S_DISPATCH: begin
          if (item_r.command == CMD_MUL) begin
            r0i_r   <= 1'b1; r0x_r <= '0; r0y_r <= '0;
            r1i_r   <= item_r.first_at_infinity; r1x_r <= px_r; r1y_r <= py_r;
            k_r     <= item_r.scalar[SW-1:0];
            kcnt_r  <= KW'(SW);
            lstep_r <= 1'b0;
            st_r    <= S_LADDER;
          end else begin
            pi_r <= item_r.first_at_infinity;
            qi_r <= item_r.second_at_infinity;
            ret_r <= S_OUT;
            st_r  <= S_PA_CHK;
          end
        end
        S_LADDER: begin
          if (kcnt_r == '0) begin
            rx_r <= r0x_r; ry_r <= r0y_r; ri_r <= r0i_r;
            st_r <= S_OUT;
          end else if (!lstep_r) begin
            // first op: r0+r1 in both branches
            px_r <= r0x_r; py_r <= r0y_r; pi_r <= r0i_r;
            qx_r <= r1x_r; qy_r <= r1y_r; qi_r <= r1i_r;
            ret_r <= S_WAITM;
            st_r  <= S_PA_CHK;
          end else begin
            // second op: doubling r1 (bit set) or r0 (bit clear)
            if (kbit) begin
              px_r <= r1x_r; py_r <= r1y_r; pi_r <= r1i_r;
              qx_r <= r1x_r; qy_r <= r1y_r; qi_r <= r1i_r;
            end else begin
              px_r <= r0x_r; py_r <= r0y_r; pi_r <= r0i_r;
              qx_r <= r0x_r; qy_r <= r0y_r; qi_r <= r0i_r;
            end
            ret_r <= S_WAITM;
            st_r  <= S_PA_CHK;
          end
        end
        S_WAITM: begin
          // store point op result into the ladder
          if (!lstep_r) begin
            if (kbit) begin
              r0x_r <= rx_r; r0y_r <= ry_r; r0i_r <= ri_r;
            end else begin
              r1x_r <= rx_r; r1y_r <= ry_r; r1i_r <= ri_r;
            end
            lstep_r <= 1'b1;
          end else begin
            if (kbit) begin
              r1x_r <= rx_r; r1y_r <= ry_r; r1i_r <= ri_r;
            end else begin
              r0x_r <= rx_r; r0y_r <= ry_r; r0i_r <= ri_r;
            end
            lstep_r <= 1'b0;
            k_r     <= {k_r[SW-2:0], 1'b0};
            kcnt_r  <= kcnt_r - 1'b1;
          end
          st_r <= S_LADDER;
        end
        S_PA_CHK: begin
          if (pi_r) begin
            rx_r <= qx_r; ry_r <= qy_r; ri_r <= qi_r; st_r <= ret_r;
          end else if (qi_r) begin
            rx_r <= px_r; ry_r <= py_r; ri_r <= 1'b0; st_r <= ret_r;
          end else if (px_r == qx_r && py_r != qy_r) begin
            ri_r <= 1'b1; rx_r <= '0; ry_r <= '0; st_r <= ret_r;
          end else if (px_r == qx_r) begin
            den_r <= f_add(py_r, py_r, p_r);
            if (f_add(py_r, py_r, p_r) == '0) begin
              ri_r <= 1'b1; rx_r <= '0; ry_r <= '0; st_r <= ret_r;
            end else begin
              mul_go <= 1'b1; mul_u <= px_r; mul_v <= FW'(3);
              st_r   <= S_PA_D0;
            end
          end else begin
            num_r <= f_sub(qy_r, py_r, p_r);
            den_r <= f_sub(qx_r, px_r, p_r);
            st_r  <= S_PA_S0;
          end
        end
        S_PA_D0: if (mul_done) begin
          mul_go <= 1'b1; mul_u <= mu_acc_r; mul_v <= px_r; st_r <= S_PA_D1;
        end
        S_PA_D1: if (mul_done) begin
          num_r <= f_add(mu_acc_r, a_r, p_r);
          st_r  <= S_PA_S0;
        end
        S_PA_S0: begin
          // Fermat inverse of den: exponent p-2 right to left
          inv_b_r   <= den_r;
          inv_e_r   <= (p_r >= FW'(2)) ? p_r - FW'(2) : '0;
          inv_r_r   <= (p_r == FW'(1)) ? '0 : FW'(1);
          inv_cnt_r <= EW'(FW);
          inv_ph_r  <= 1'b0;
          st_r      <= S_INV;
        end
        S_INV: begin
          if (inv_cnt_r == '0 || inv_e_r == '0) begin
            mul_go <= 1'b1; mul_u <= num_r; mul_v <= inv_r_r; st_r <= S_LAM;
          end else if (!inv_ph_r) begin
            if (inv_e_r[0]) begin
              mul_go <= 1'b1; mul_u <= inv_r_r; mul_v <= inv_b_r; st_r <= S_INV_M;
            end else begin
              inv_ph_r <= 1'b1;
            end
          end else begin
            mul_go <= 1'b1; mul_u <= inv_b_r; mul_v <= inv_b_r; st_r <= S_INV_M;
          end
        end
        S_INV_M: if (mul_done) begin
          if (!inv_ph_r) begin
            inv_r_r  <= mu_acc_r;
            inv_ph_r <= 1'b1;
          end else begin
            inv_b_r   <= mu_acc_r;
            inv_ph_r  <= 1'b0;
            inv_e_r   <= inv_e_r >> 1;
            inv_cnt_r <= inv_cnt_r - 1'b1;
          end
          st_r <= S_INV;
        end
        S_LAM: if (mul_done) begin
          lam_r  <= mu_acc_r;
          mul_go <= 1'b1; mul_u <= mu_acc_r; mul_v <= mu_acc_r;
          st_r   <= S_X3;
        end
        S_X3: if (mul_done) begin
          rx_r   <= f_sub(f_sub(mu_acc_r, px_r, p_r), qx_r, p_r);
          mul_go <= 1'b1; mul_u <= lam_r;
          mul_v  <= f_sub(px_r, f_sub(f_sub(mu_acc_r, px_r, p_r), qx_r, p_r), p_r);
          st_r   <= S_Y3;
        end
        S_Y3: if (mul_done) begin
          ry_r <= f_sub(mu_acc_r, py_r, p_r);
          ri_r <= 1'b0;
          st_r <= ret_r;
        end
        S_OUT: begin
          out_v_r <= 1'b1;
          out_r.result_x           <= ri_r ? '0 : rx_r;
          out_r.result_y           <= ri_r ? '0 : ry_r;
          out_r.result_at_infinity <= ri_r;
          out_r.curve_singular     <= sing_r;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // assertions
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_busy) else $error("busy during result");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_mul_go: assert property (@(posedge clk) disable iff (!rst_n)
    mul_go |-> !mul_busy_r) else $error("multiplier restarted while busy");
  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_at_infinity |-> out_data.result_x == '0)
    else $error("infinity with nonzero x");

endmodule
